@@ sv/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the smooth-colored escape-time pixel block.
// ----------------------------------------------------------------------------
package msp_pkg;

	localparam int COORD_FRAC_BITS = 28;
	localparam int ITER_LIMIT_MAX  = 255;
	localparam int LOG2_TWO_LN2_Q16 = 30883;
	localparam logic [7:0] MAX_ITER_RESET = 8'd100;
	localparam logic [63:0] FOUR_FIX = 64'd4 << COORD_FRAC_BITS;
	localparam logic [62:0] SAT_POS = {63{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_FIN,
		ST_NORM,
		ST_LMUL,
		ST_LADJ,
		ST_SMOOTH,
		ST_DIV1,
		ST_DIV2,
		ST_HMUL,
		ST_HUE,
		ST_OUT
	} msp_state_t;

	typedef enum logic [1:0] {
		OP_XY,
		OP_XX,
		OP_YY
	} msp_op_t;

endpackage

@@ sv/msp_if.sv @@
// ----------------------------------------------------------------------------
// msp channel interfaces
// Point, pixel and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface msp_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] c_real;
	logic signed [31:0] c_imag;
	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface msp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       in_set;
	logic [7:0] escape_count;
	modport source (output valid, output red, output green, output blue,
		output in_set, output escape_count, input ready);
	modport sink   (input valid, input red, input green, input blue,
		input in_set, input escape_count, output ready);
endinterface

interface msp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/mandelbrot_smooth_pixel_color_top.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_smooth_pixel_color_top
// Escape-time Mandelbrot pixel with smooth coloring, one shared multiplier.
// ----------------------------------------------------------------------------
// Each iteration: escape test, then three 64-bit products, each built from four
// 32x32 partials in the multiply state and closed by a finish step; a point that
// reaches the limit goes from its last finish step to the output register.
// An escaped point then goes through normalize, log2, smooth value, up to two hue
// divisions (none when the smooth value reaches the limit), coloring and the output register.
// Throughput: one item at a time; the point channel is ready only when idle.
// Reset: arst_n clears the sequencer and output valid and sets the limit to 100.
// ----------------------------------------------------------------------------
module mandelbrot_smooth_pixel_color_top
	import msp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	msp_point_if.sink      point,
	msp_pixel_if.source    pixel,
	msp_cfg_if.sink        cfg
);

	localparam int SH_XY = COORD_FRAC_BITS - 1;
	localparam int SH_SQ = COORD_FRAC_BITS;

	msp_state_t state_q, state_d;

	// Configuration register; writes are taken at any time.
	logic [7:0] max_iter_q;
	logic [7:0] lim;

	// Iteration datapath.
	logic signed [63:0] cr_q, ci_q;
	logic [63:0] x_q, y_q;
	logic [62:0] x2_q, y2_q;
	logic [7:0]  n_q;
	msp_op_t     op_q;
	logic [2:0]  k_q;
	logic [127:0] acc_q;

	// Log2 and hue datapath.
	logic [63:0] m_q, m_next;
	logic [5:0]  p_q, p_next;
	logic [2:0]  nk_q;
	logic [31:0] lv_q;
	logic [3:0]  li_q;
	logic [15:0] frac_q;
	logic [7:0]  ip_q;
	logic [15:0] fp_q;
	logic [15:0] h1_q, h2_q;

	// Result waiting for the output register, and the output register.
	logic [7:0] res_r_q, res_g_q, res_b_q, res_n_q;
	logic       res_set_q;
	logic       pix_valid_q;
	logic [7:0] pix_r_q, pix_g_q, pix_b_q, pix_n_q;
	logic       pix_set_q;

	// Shared units.
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_q;
	logic        div_start;
	logic [23:0] div_dividend;
	logic        div_done;
	logic [23:0] div_quo;

	msp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_q));

	msp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(lim), .done_q(div_done), .quo_q(div_quo)
	);

	assign lim = (32'(max_iter_q) > ITER_LIMIT_MAX) ? 8'(ITER_LIMIT_MAX) : max_iter_q;

	// Magnitudes and the escape test.
	logic [63:0] mag_x, mag_y, op_a, op_b;
	logic [64:0] mag_sum;
	logic        escape;
	logic        reached;

	assign mag_x   = x_q[63] ? 64'd0 - x_q : x_q;
	assign mag_y   = y_q[63] ? 64'd0 - y_q : y_q;
	assign mag_sum = {2'b0, x2_q} + {2'b0, y2_q};
	assign escape  = mag_sum > {1'b0, FOUR_FIX};
	assign reached = n_q >= lim;

	always_comb begin
		case (op_q)
			OP_XY: begin op_a = mag_x; op_b = mag_y; end
			OP_XX: begin op_a = mag_x; op_b = mag_x; end
			default: begin op_a = mag_y; op_b = mag_y; end
		endcase
	end

	// Finishing a product: shift by the fraction width (one less for x*y), saturate to 2^63-1.
	logic [62:0] r_xy, r_sq, r_fin;
	logic [63:0] y_new, x_new;
	logic [1:0]  jp;
	logic [127:0] acc_add;

	assign r_xy  = (|(acc_q >> (SH_XY + 63))) ? SAT_POS : acc_q[SH_XY + 62 -: 63];
	assign r_sq  = (|(acc_q >> (SH_SQ + 63))) ? SAT_POS : acc_q[SH_SQ + 62 -: 63];
	assign r_fin = (op_q == OP_XY) ? r_xy : r_sq;
	assign y_new = ((x_q[63] ^ y_q[63]) ? 64'd0 - {1'b0, r_fin} : {1'b0, r_fin})
		+ 64'(ci_q);
	assign x_new = {1'b0, x2_q} - {1'b0, y2_q} + 64'(cr_q);

	assign jp = 2'(k_q - 3'd1);
	always_comb begin
		case (jp)
			2'd0: acc_add = {64'd0, mul_q};
			2'd3: acc_add = {mul_q, 64'd0};
			default: acc_add = {32'd0, mul_q, 32'd0};
		endcase
	end

	// Normalization step: test the top 32, 16, ... 1 bits for zero.
	logic [5:0] amt;
	assign amt = 6'(6'd32 >> nk_q);
	always_comb begin
		if ((m_q >> (7'd64 - 7'(amt))) == 64'd0) begin
			m_next = m_q << amt;
			p_next = p_q - amt;
		end else begin
			m_next = m_q;
			p_next = p_q;
		end
	end

	// Log2 squaring round.
	logic [32:0] sq_t;
	assign sq_t = mul_q[63:31];

	// Smooth value.
	logic signed [31:0] l2_s, sm_s;
	logic [31:0] sm_c;
	logic [8:0]  n_p1;
	logic        smooth_set;
	logic [8:0]  ip_p1;

	assign n_p1  = {1'b0, n_q} + 9'd1;
	assign l2_s  = $signed((({26'd0, p_q} - 32'(COORD_FRAC_BITS)) << 16) + {16'd0, frac_q});
	assign sm_s  = $signed({7'd0, n_p1, 16'd0}) + (l2_s >>> 1) - 32'sd30883;
	assign sm_c  = sm_s[31] ? 32'd0 : sm_s;
	assign smooth_set = (sm_c >= {8'd0, lim, 16'd0}) || (lim == 8'd0);
	assign ip_p1 = {1'b0, ip_q} + 9'd1;

	// Hue interpolation.
	logic        h_up;
	logic [15:0] h_diff;
	logic [15:0] hue16;
	logic [7:0]  col_r, col_g, col_b;

	assign h_up   = h2_q >= h1_q;
	assign h_diff = h_up ? h2_q - h1_q : h1_q - h2_q;
	assign hue16  = h_up ? h1_q + mul_q[31:16] : h1_q - mul_q[31:16];

	msp_color u_color (.hue(hue16), .red(col_r), .green(col_g), .blue(col_b));

	logic out_free;
	assign out_free = !pix_valid_q || pixel.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (point.valid) state_d = ST_CHECK;
			ST_CHECK:  state_d = escape ? ST_NORM : ST_MUL;
			ST_MUL:    if (k_q == 3'd4) state_d = ST_FIN;
			ST_FIN: begin
				if (op_q != OP_YY) state_d = ST_MUL;
				else if (reached) state_d = ST_OUT;
				else state_d = ST_CHECK;
			end
			ST_NORM:   if (nk_q == 3'd5) state_d = ST_LMUL;
			ST_LMUL:   state_d = ST_LADJ;
			ST_LADJ:   state_d = (li_q == 4'd15) ? ST_SMOOTH : ST_LMUL;
			ST_SMOOTH: state_d = smooth_set ? ST_OUT : ST_DIV1;
			ST_DIV1: begin
				if (div_done) state_d = (ip_p1 >= {1'b0, lim}) ? ST_HMUL : ST_DIV2;
			end
			ST_DIV2:   if (div_done) state_d = ST_HMUL;
			ST_HMUL:   state_d = ST_HUE;
			ST_HUE:    state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs: handshakes, multiplier operands, divider start.
	always_comb begin
		point.ready  = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = {ip_q, 16'd0};
		case (state_q)
			ST_IDLE: point.ready = 1'b1;
			ST_MUL: begin
				mul_a = k_q[0] ? op_a[63:32] : op_a[31:0];
				mul_b = k_q[1] ? op_b[63:32] : op_b[31:0];
			end
			ST_LMUL: begin
				mul_a = lv_q;
				mul_b = lv_q;
			end
			ST_HMUL: begin
				mul_a = {16'd0, fp_q};
				mul_b = {16'd0, h_diff};
			end
			ST_SMOOTH: begin
				div_start    = !smooth_set;
				div_dividend = {sm_c[23:16], 16'd0};
			end
			ST_DIV1: begin
				div_start    = div_done && (ip_p1 < {1'b0, lim});
				div_dividend = {ip_p1[7:0], 16'd0};
			end
			default: ;
		endcase
	end

	assign cfg.ready          = 1'b1;
	assign pixel.valid        = pix_valid_q;
	assign pixel.red          = pix_r_q;
	assign pixel.green        = pix_g_q;
	assign pixel.blue         = pix_b_q;
	assign pixel.in_set       = pix_set_q;
	assign pixel.escape_count = pix_n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_iter_q  <= MAX_ITER_RESET;
			pix_valid_q <= 1'b0;
			k_q         <= '0;
			op_q        <= OP_XY;
			nk_q        <= '0;
			li_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) max_iter_q <= cfg.data;
			if (pix_valid_q && pixel.ready) pix_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (point.valid) begin
						cr_q <= 64'(point.c_real);
						ci_q <= 64'(point.c_imag);
						x_q  <= '0;
						y_q  <= '0;
						x2_q <= '0;
						y2_q <= '0;
						n_q  <= '0;
					end
				end
				ST_CHECK: begin
					op_q  <= OP_XY;
					k_q   <= '0;
					acc_q <= '0;
					m_q   <= mag_sum[63:0];
					p_q   <= 6'd63;
					nk_q  <= '0;
				end
				ST_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q != 3'd0) acc_q <= acc_q + acc_add;
				end
				ST_FIN: begin
					k_q   <= '0;
					acc_q <= '0;
					case (op_q)
						OP_XY: begin
							y_q  <= y_new;
							x_q  <= x_new;
							op_q <= OP_XX;
						end
						OP_XX: begin
							x2_q <= r_fin;
							op_q <= OP_YY;
						end
						default: begin
							y2_q <= r_fin;
							op_q <= OP_XY;
							if (reached) begin
								res_set_q <= 1'b1;
								res_r_q   <= '0;
								res_g_q   <= '0;
								res_b_q   <= '0;
								res_n_q   <= n_q;
							end else begin
								n_q <= n_q + 8'd1;
							end
						end
					endcase
				end
				ST_NORM: begin
					m_q  <= m_next;
					p_q  <= p_next;
					nk_q <= nk_q + 3'd1;
					if (nk_q == 3'd5) begin
						lv_q   <= m_next[63:32];
						li_q   <= '0;
						frac_q <= '0;
						nk_q   <= '0;
					end
				end
				ST_LADJ: begin
					frac_q <= {frac_q[14:0], sq_t[32]};
					lv_q   <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
					li_q   <= li_q + 4'd1;
				end
				ST_SMOOTH: begin
					ip_q    <= sm_c[23:16];
					fp_q    <= sm_c[15:0];
					res_n_q <= n_q;
					if (smooth_set) begin
						res_set_q <= 1'b1;
						res_r_q   <= '0;
						res_g_q   <= '0;
						res_b_q   <= '0;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						h1_q <= div_quo[15:0];
						h2_q <= '0;
					end
				end
				ST_DIV2: if (div_done) h2_q <= div_quo[15:0];
				ST_HUE: begin
					res_set_q <= 1'b0;
					res_r_q   <= col_r;
					res_g_q   <= col_g;
					res_b_q   <= col_b;
				end
				ST_OUT: begin
					if (out_free) begin
						pix_valid_q <= 1'b1;
						pix_r_q     <= res_r_q;
						pix_g_q     <= res_g_q;
						pix_b_q     <= res_b_q;
						pix_set_q   <= res_set_q;
						pix_n_q     <= res_n_q;
					end
				end
				default: ;
			endcase
		end
	end

	// A point flagged inside the set always leaves as black.
	a_inset_black: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.in_set |-> (pixel.red == 8'd0 && pixel.green == 8'd0
			&& pixel.blue == 8'd0))
		else $error("in-set pixel is not black");

	// An accepted point starts with the escape test.
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready |=> state_q == ST_CHECK)
		else $error("accepted point did not start iterating");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider finished outside a divide step");

endmodule

@@ sv/msp_mul.sv @@
// ----------------------------------------------------------------------------
// msp_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module msp_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

@@ sv/msp_div.sv @@
// ----------------------------------------------------------------------------
// msp_div
// Restoring divider, one quotient bit per cycle, 24-bit by 8-bit.
// ----------------------------------------------------------------------------
module msp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done_q,
	output logic [23:0] quo_q
);

	logic [7:0] rem_q;
	logic [7:0] dvs_q;
	logic [4:0] cnt_q;
	logic       busy_q;
	logic [8:0] trial;
	logic       fits;

	assign trial = {rem_q, quo_q[23]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
				quo_q <= {quo_q[22:0], fits};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ sv/msp_color.sv @@
// ----------------------------------------------------------------------------
// msp_color
// Hue to truncated 8-bit RGB by sextant.
// ----------------------------------------------------------------------------
module msp_color (
	input  logic [15:0] hue,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	logic [18:0] h6;
	logic [2:0]  sext;
	logic [15:0] gf;
	logic [23:0] up_p;
	logic [16:0] dn_d;
	logic [24:0] dn_p;
	logic [7:0]  up;
	logic [7:0]  dn;

	always_comb begin
		h6   = ({3'b0, hue} << 2) + ({3'b0, hue} << 1);
		sext = h6[18:16];
		gf   = h6[15:0];
		up_p = {gf, 8'd0} - {8'd0, gf};
		up   = up_p[23:16];
		dn_d = 17'h10000 - {1'b0, gf};
		dn_p = {dn_d, 8'd0} - {8'd0, dn_d};
		dn   = dn_p[23:16];
		case (sext)
			3'd1: begin red = dn;    green = 8'hFF; blue = 8'h00; end
			3'd2: begin red = 8'h00; green = 8'hFF; blue = up;    end
			3'd3: begin red = 8'h00; green = dn;    blue = 8'hFF; end
			3'd4: begin red = up;    green = 8'h00; blue = 8'hFF; end
			3'd5: begin red = 8'hFF; green = 8'h00; blue = dn;    end
			default: begin red = 8'hFF; green = up; blue = 8'h00; end
		endcase
	end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the smooth-colored escape-time pixel block: directed
// points and random points under several iteration limits, each pixel
// compared field by field with a behavioral prediction.
// ----------------------------------------------------------------------------
module tb
	import msp_pkg::*;
;

	// One expected pixel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       in_set;
		logic [7:0] escape_count;
	} pixel_t;

	// One row of the directed table. When has_pix is set, pix is the pixel
	// typed in by hand and it must also agree with the prediction.
	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		bit                 has_pix;
		pixel_t             pix;
	} point_row_t;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES   = 6000;
	localparam int MAX_REPORTS    = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	msp_point_if point ();
	msp_pixel_if pixel ();
	msp_cfg_if   cfg ();

	mandelbrot_smooth_pixel_color_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point.sink),
		.pixel  (pixel.source),
		.cfg    (cfg.sink)
	);

	always #10 clk = ~clk;

	// The bench's own copy of the iteration limit register.
	logic [7:0] iter_limit_reg = MAX_ITER_RESET;

	pixel_t pending_pixels[$];
	int     mismatch_count = 0;
	int     pixel_count = 0;
	int     inset_count = 0;
	int     idle_cycles = 0;
	bit     stall_enable = 1'b1;

	// |a*b| >> sh, truncated toward zero and saturated to 2^63-1.
	function automatic logic [63:0] mag_product(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] full;
		logic [127:0] shifted;
		full = {64'd0, a} * {64'd0, b};
		shifted = full >> sh;
		if (shifted > {65'd0, SAT_POS}) begin
			return {1'b0, SAT_POS};
		end
		return shifted[63:0];
	endfunction

	function automatic logic [63:0] abs64(logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// 16.16 logarithm base two of a sum of squares with COORD_FRAC_BITS fraction bits.
	function automatic logic signed [31:0] log2_fix(logic [63:0] m);
		int lead;
		logic [63:0] mant;
		logic [127:0] sq;
		logic [15:0] frac;
		lead = 63;
		frac = '0;
		if (m == 0) begin
			return 0;
		end
		while (m[lead] == 1'b0) begin
			lead--;
		end
		mant = lead >= 31 ? m >> (lead - 31) : m << (31 - lead);
		for (int k = 0; k < 16; k++) begin
			sq = {64'd0, mant} * {64'd0, mant};
			mant = sq[94:31];
			frac = {frac[14:0], 1'b0};
			if (mant >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		return (lead - COORD_FRAC_BITS) * 65536 + frac;
	endfunction

	function automatic logic [7:0] ramp_up(logic [15:0] g);
		return 8'(({16'd0, g} * 32'd255) >> 16);
	endfunction

	function automatic logic [7:0] ramp_down(logic [15:0] g);
		return 8'(((32'd65536 - g) * 32'd255) >> 16);
	endfunction

	// Escape-time iteration, smooth value, hue and sextant coloring of one point.
	function automatic pixel_t color_point(logic signed [31:0] re, logic signed [31:0] im,
		logic [7:0] limit_reg);
		logic signed [63:0] cr, ci, x, y, xy;
		logic [63:0] x2, y2, lim, four;
		logic [63:0] iters;
		logic signed [31:0] smooth;
		logic [31:0] ip, fp, h1, h2, hue, h6, sext, gf;
		bit reached;
		pixel_t px;
		cr = re;
		ci = im;
		lim = limit_reg > ITER_LIMIT_MAX ? ITER_LIMIT_MAX : limit_reg;
		four = FOUR_FIX;
		x = 0;
		y = 0;
		x2 = 0;
		y2 = 0;
		iters = 0;
		reached = 1'b0;
		px = '0;
		forever begin
			if (x2 + y2 > four) break;
			xy = signed'(mag_product(abs64(x), abs64(y), COORD_FRAC_BITS - 1));
			if ((x < 0) != (y < 0)) xy = -xy;
			y = xy + ci;
			x = signed'(x2) - signed'(y2) + cr;
			x2 = mag_product(abs64(x), abs64(x), COORD_FRAC_BITS);
			y2 = mag_product(abs64(y), abs64(y), COORD_FRAC_BITS);
			if (iters >= lim) begin
				reached = 1'b1;
				break;
			end
			iters++;
		end
		px.escape_count = iters[7:0];
		if (reached) begin
			px.in_set = 1'b1;
			return px;
		end
		smooth = 32'((iters + 1) * 65536) + (log2_fix(x2 + y2) >>> 1) - LOG2_TWO_LN2_Q16;
		if (smooth < 0) smooth = 0;
		if (64'(unsigned'(smooth)) >= (lim << 16) || lim == 0) begin
			px.in_set = 1'b1;
			return px;
		end
		ip = unsigned'(smooth) >> 16;
		fp = unsigned'(smooth) & 32'hFFFF;
		h1 = 32'((64'(ip) << 16) / lim);
		h2 = (64'(ip) + 1 >= lim) ? 0 : 32'((64'(ip + 1) << 16) / lim);
		if (h2 >= h1) hue = h1 + 32'((64'(fp) * (h2 - h1)) >> 16);
		else hue = h1 - 32'((64'(fp) * (h1 - h2)) >> 16);
		h6 = (hue & 32'hFFFF) * 6;
		sext = h6 >> 16;
		gf = h6 & 32'hFFFF;
		case (sext)
			1: begin
				px.red = ramp_down(gf[15:0]); px.green = 8'd255; px.blue = 8'd0;
			end
			2: begin
				px.red = 8'd0; px.green = 8'd255; px.blue = ramp_up(gf[15:0]);
			end
			3: begin
				px.red = 8'd0; px.green = ramp_down(gf[15:0]); px.blue = 8'd255;
			end
			4: begin
				px.red = ramp_up(gf[15:0]); px.green = 8'd0; px.blue = 8'd255;
			end
			5: begin
				px.red = 8'd255; px.green = 8'd0; px.blue = ramp_down(gf[15:0]);
			end
			default: begin
				px.red = 8'd255; px.green = ramp_up(gf[15:0]); px.blue = 8'd0;
			end
		endcase
		return px;
	endfunction

	function automatic bit should_idle();
		return stall_enable && ($urandom_range(99) < 37);
	endfunction

	// Sender side. Every accepted point queues its predicted pixel. After an
	// accept the valid line is dropped before the next point may raise it;
	// the block does not accept a new point until it is idle again anyway.
	task automatic send_point(logic signed [31:0] re, logic signed [31:0] im);
		while (should_idle()) begin
			@(posedge clk);
		end
		point.valid <= 1'b1;
		point.c_real <= re;
		point.c_imag <= im;
		do begin
			@(posedge clk);
		end while (!point.ready);
		pending_pixels.push_back(color_point(re, im, iter_limit_reg));
		point.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every queued pixel has arrived, then lets the block settle
	// before the register may change.
	task automatic wait_drained();
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(logic [7:0] value);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		cfg.valid <= 1'b0;
		iter_limit_reg = value;
	endtask

	// Random Q4.28 point: mostly around the interesting region, some anywhere.
	task automatic send_random_point();
		logic signed [31:0] re, im;
		case ($urandom_range(9))
			0, 1: begin
				re = $urandom;
				im = $urandom;
			end
			2: begin
				re = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(255)
					: 32'sh8000_0000 + $urandom_range(255);
				im = $urandom;
			end
			default: begin
				re = $signed($urandom_range(32'h3000_0000)) - 32'sh2000_0000;
				im = $signed($urandom_range(32'h2400_0000)) - 32'sh1200_0000;
			end
		endcase
		send_point(re, im);
	endtask

	// Receiver side: ready idles at random, every pixel is checked in order.
	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			pixel.ready <= 1'b0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				got = '{pixel.red, pixel.green, pixel.blue, pixel.in_set, pixel.escape_count};
				pixel_count++;
				if (got.in_set) inset_count++;
				if (pending_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected pixel %p", got);
				end else begin
					want = pending_pixels.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("pixel mismatch: expected %p, got %p", want, got);
					end
				end
			end
			pixel.ready <= !should_idle();
		end
	end

	// Watchdog: counts cycles without any accepted handshake.
	always @(posedge clk) begin
		if ((point.valid && point.ready) || (pixel.valid && pixel.ready)
			|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d pixels outstanding", pending_pixels.size());
			$display("mandelbrot_smooth_pixel_color_top regression: fail");
			$finish;
		end
	end

	localparam logic signed [31:0] ONE_Q = 32'sh1000_0000;

	// Directed points. Hand-typed pixels hold for the reset limit of 100.
	point_row_t directed[] = '{
		'{32'sd0, 32'sd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 8'd100}},
		'{-ONE_Q, 32'sd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 8'd100}},
		'{32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, '0},
		'{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
		'{32'sh7FFF_FFFF, 32'sd0, 1'b0, '0},
		'{32'sd0, 32'sh8000_0000, 1'b0, '0},
		'{-32'sh2000_0000, 32'sd0, 1'b0, '0},
		'{32'sh0400_0000, 32'sd0, 1'b0, '0},
		'{32'sh0410_0000, 32'sd0, 1'b0, '0},
		'{-32'sh0C00_0000, 32'sh0200_0000, 1'b0, '0},
		'{32'sh0600_0000, 32'sh0A00_0000, 1'b0, '0},
		'{-32'sh1C00_0000, 32'sh0100_0000, 1'b0, '0},
		'{32'sd0, ONE_Q, 1'b0, '0},
		'{32'sh0300_0000, 32'sh0900_0000, 1'b0, '0},
		'{-32'sh0800_0000, 32'sh0A80_0000, 1'b0, '0},
		'{32'sh0500_0000, -32'sh0500_0000, 1'b0, '0},
		'{32'shFFFF_FFFF, 32'sh5555_5555, 1'b0, '0},
		'{32'sh2AAA_AAAA, 32'shAAAA_AAAA, 1'b0, '0}
	};

	logic [7:0] limit_plan[] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd37, 8'd16, 8'd100};

	initial begin
		pixel_t want;
		point.valid = 1'b0;
		point.c_real = '0;
		point.c_imag = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset limit.
		foreach (directed[k]) begin
			if (directed[k].has_pix) begin
				want = color_point(directed[k].re, directed[k].im, iter_limit_reg);
				if (want !== directed[k].pix) begin
					mismatch_count++;
					$display("table row %0d disagrees with prediction: %p vs %p",
						k, directed[k].pix, want);
				end
			end
			send_point(directed[k].re, directed[k].im);
		end
		wait_drained();

		// Random phases, each under its own limit; the middle phase runs with
		// no idling on either side. Mostly small limits keep the run short.
		foreach (limit_plan[p]) begin
			write_limit(limit_plan[p]);
			stall_enable = (p != 3);
			for (int k = 0; k < (limit_plan[p] >= 200 ? 30 : 80); k++) begin
				send_random_point();
				// In the longer phases, hold off once until every pixel is back.
				if (k == 40) wait_drained();
			end
			wait_drained();
		end
		stall_enable = 1'b1;

		// Random register values for the tail, eight points each.
		repeat (4) begin
			write_limit(8'($urandom));
			repeat (8) send_random_point();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d pixels, %0d inside the set, over %0d limit settings.",
			pixel_count, inset_count, limit_plan.size() + 5);
		if (mismatch_count == 0 && pending_pixels.size() == 0) begin
			$display("mandelbrot_smooth_pixel_color_top regression: pass");
		end else begin
			$display("mandelbrot_smooth_pixel_color_top regression: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/msp_pkg.sv
sv/msp_if.sv
sv/msp_mul.sv
sv/msp_div.sv
sv/msp_color.sv
sv/mandelbrot_smooth_pixel_color_top.sv
sim/tb.sv
